/* rtl/interval_value_table_defines.svh */
// Assertion macros shared by the interval value table RTL.
`ifndef INTERVAL_VALUE_TABLE_DEFINES_SVH
`define INTERVAL_VALUE_TABLE_DEFINES_SVH

// same-cycle implication
`define IVT_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define IVT_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/ivt_pkg.sv */
// Types and constants of the interval value table.
package ivt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int KEY_BITS    = 16;
   localparam int VALUE_BITS  = 8;
   localparam int IDX_BITS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int NEED_BITS   = CNT_BITS + 1;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [NEED_BITS-1:0]  need_type;

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // control broadcast to every cell
   typedef struct packed {
      logic      wr_b;
      logic      wr_e;
      logic      shl;
      logic      shr;
      cnt_type   shift_from;
      idx_type   lo;
      idx_type   lo_next;
      key_type   key_b;
      value_type value_b;
      key_type   key_e;
      value_type value_e;
   } cell_ctrl_type;

   // keys every cell compares against
   typedef struct packed {
      key_type key_b;
      key_type key_e;
      key_type key_q;
      cnt_type count;
   } cell_query_type;

   typedef struct packed {
      logic lt_b;
      logic lt_e;
      logic eq_e;
      logic le_q;
   } cell_flags_type;

endpackage

/* rtl/ivt_cell.sv */
// One boundary entry of the table: compares and shifts with its neighbours.
module ivt_cell (
   input  logic                    clock,
   input  ivt_pkg::idx_type        cell_idx,
   input  ivt_pkg::cell_ctrl_type  ctrl,
   input  ivt_pkg::cell_query_type query,
   input  ivt_pkg::key_type        left_key,
   input  ivt_pkg::value_type      left_value,
   input  ivt_pkg::key_type        right_key,
   input  ivt_pkg::value_type      right_value,
   output ivt_pkg::key_type        key_out,
   output ivt_pkg::value_type      value_out,
   output ivt_pkg::cell_flags_type flags
);

   ivt_pkg::key_type   key_ff,   key_in;
   ivt_pkg::value_type value_ff, value_in;
   logic               occ;
   logic               in_shift;

   assign occ      = ivt_pkg::cnt_type'(cell_idx) < query.count;
   assign in_shift = ivt_pkg::cnt_type'(cell_idx) >= ctrl.shift_from;

   assign flags.lt_b = occ && (key_ff <  query.key_b);
   assign flags.lt_e = occ && (key_ff <  query.key_e);
   assign flags.eq_e = occ && (key_ff == query.key_e);
   assign flags.le_q = occ && (key_ff <= query.key_q);

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctrl.wr_b && (cell_idx == ctrl.lo)) begin
         key_in   = ctrl.key_b;
         value_in = ctrl.value_b;
      end else if (ctrl.wr_e && (cell_idx == ctrl.lo_next)) begin
         key_in   = ctrl.key_e;
         value_in = ctrl.value_e;
      end else if (ctrl.shl && in_shift) begin
         key_in   = right_key;
         value_in = right_value;
      end else if (ctrl.shr && in_shift) begin
         key_in   = left_key;
         value_in = left_value;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;

endmodule

/* rtl/interval_value_table.sv */
// Interval value table: a sorted row of boundary cells, each starting a run of one value, with
// keys below the first boundary reading the default register. An item is accepted when start is
// high and busy low. A lookup is compared in all cells in the cycle after acceptance and its
// result is registered and strobes in the cycle after the compare. An assign is compared the same way,
// then the entries above the interval move one cell per cycle until they sit just past the new
// boundaries, then the new boundaries are written. The tail moves from hi to lo + 1 + ins, where lo and
// hi are the first entries at or above begin and end and ins is 1 when end is not yet a boundary
// (0 otherwise). An ignored or refused assign strobes its result as a lookup does. The result
// strobe rsp_valid lasts one cycle and cannot be held off; busy is already low in that cycle.
module interval_value_table (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_op,
   input  logic [15:0]             req_key,
   input  logic [15:0]             req_key_end,
   input  logic [7:0]              req_value,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_read_value,
   output logic [1:0]              rsp_status,
   input  logic                    csr_we,
   input  logic [7:0]              csr_wdata
);

`include "interval_value_table_defines.svh"

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SHIFT
   } state_type;

   state_type          state_ff, state_in;
   ivt_pkg::cnt_type   count_ff, count_in;
   ivt_pkg::value_type default_ff;
   logic               op_ff, op_in;
   ivt_pkg::key_type   key_ff, key_in;
   ivt_pkg::key_type   end_ff, end_in;
   ivt_pkg::value_type value_ff, value_in;
   ivt_pkg::cnt_type   lo_ff, lo_in;
   ivt_pkg::cnt_type   tgt_ff, tgt_in;
   ivt_pkg::cnt_type   cur_ff, cur_in;
   ivt_pkg::cnt_type   need_ff, need_in;
   logic               ins2_ff, ins2_in;
   ivt_pkg::value_type end_val_ff, end_val_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ivt_pkg::value_type rsp_read_value_ff, rsp_read_value_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   ivt_pkg::cell_ctrl_type  ctrl;
   ivt_pkg::cell_query_type query;
   ivt_pkg::key_type        cell_key   [ivt_pkg::TABLE_DEPTH];
   ivt_pkg::value_type      cell_val   [ivt_pkg::TABLE_DEPTH];
   ivt_pkg::cell_flags_type cell_flags [ivt_pkg::TABLE_DEPTH];
   logic [ivt_pkg::TABLE_DEPTH:0] lt_b_v, lt_e_v, le_q_v;
   logic [ivt_pkg::TABLE_DEPTH-1:0] eq_e_v;

   ivt_pkg::cnt_type   lo_c, hi_c;
   logic               ep_c;
   ivt_pkg::value_type q_sel_c, q_val_c;
   ivt_pkg::need_type  need_c, tgt_c;

   assign query.key_b = key_ff;
   assign query.key_e = end_ff;
   assign query.key_q = (op_ff == ivt_pkg::OP_LOOKUP) ? key_ff : end_ff;
   assign query.count = count_ff;

   assign lt_b_v[ivt_pkg::TABLE_DEPTH] = 1'b0;
   assign lt_e_v[ivt_pkg::TABLE_DEPTH] = 1'b0;
   assign le_q_v[ivt_pkg::TABLE_DEPTH] = 1'b0;

   for (genvar j = 0; j < ivt_pkg::TABLE_DEPTH; j++) begin : g_cell
      ivt_pkg::key_type   left_key, right_key;
      ivt_pkg::value_type left_value, right_value;

      if (j == 0) begin : g_first
         assign left_key   = '0;
         assign left_value = '0;
      end else begin : g_inner_l
         assign left_key   = cell_key[j-1];
         assign left_value = cell_val[j-1];
      end
      if (j == ivt_pkg::TABLE_DEPTH - 1) begin : g_last
         assign right_key   = '0;
         assign right_value = '0;
      end else begin : g_inner_r
         assign right_key   = cell_key[j+1];
         assign right_value = cell_val[j+1];
      end

      ivt_cell u_cell (
         .clock       (clock),
         .cell_idx    (ivt_pkg::idx_type'(j)),
         .ctrl        (ctrl),
         .query       (query),
         .left_key    (left_key),
         .left_value  (left_value),
         .right_key   (right_key),
         .right_value (right_value),
         .key_out     (cell_key[j]),
         .value_out   (cell_val[j]),
         .flags       (cell_flags[j])
      );

      assign lt_b_v[j] = cell_flags[j].lt_b;
      assign lt_e_v[j] = cell_flags[j].lt_e;
      assign le_q_v[j] = cell_flags[j].le_q;
      assign eq_e_v[j] = cell_flags[j].eq_e;
   end

   // cells are sorted, so each flag row is a thermometer; its edge gives the position
   always_comb begin
      lo_c    = '0;
      hi_c    = '0;
      q_sel_c = '0;
      for (int j = 0; j < ivt_pkg::TABLE_DEPTH; j++) begin
         if (lt_b_v[j] && !lt_b_v[j+1]) begin
            lo_c = lo_c | ivt_pkg::cnt_type'(j + 1);
         end
         if (lt_e_v[j] && !lt_e_v[j+1]) begin
            hi_c = hi_c | ivt_pkg::cnt_type'(j + 1);
         end
         if (le_q_v[j] && !le_q_v[j+1]) begin
            q_sel_c = q_sel_c | cell_val[j];
         end
      end
      ep_c    = |eq_e_v;
      q_val_c = le_q_v[0] ? q_sel_c : default_ff;
      need_c  = ivt_pkg::need_type'(count_ff) + (ep_c ? 2'd1 : 2'd2)
                - ivt_pkg::need_type'(hi_c - lo_c);
      tgt_c   = ivt_pkg::need_type'(lo_c) + (ep_c ? 2'd1 : 2'd2);
   end

   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      op_in             = op_ff;
      key_in            = key_ff;
      end_in            = end_ff;
      value_in          = value_ff;
      lo_in             = lo_ff;
      tgt_in            = tgt_ff;
      cur_in            = cur_ff;
      need_in           = need_ff;
      ins2_in           = ins2_ff;
      end_val_in        = end_val_ff;
      rsp_valid_in      = 1'b0;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;

      ctrl            = '0;
      ctrl.lo         = lo_ff[ivt_pkg::IDX_BITS-1:0];
      ctrl.lo_next    = ivt_pkg::idx_type'(lo_ff + 1'b1);
      ctrl.key_b      = key_ff;
      ctrl.value_b    = value_ff;
      ctrl.key_e      = end_ff;
      ctrl.value_e    = end_val_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               key_in   = req_key;
               end_in   = req_key_end;
               value_in = req_value;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in          = ST_IDLE;
            rsp_valid_in      = 1'b1;
            rsp_read_value_in = '0;
            rsp_status_in     = ivt_pkg::STATUS_DONE;
            if (op_ff == ivt_pkg::OP_LOOKUP) begin
               rsp_read_value_in = q_val_c;
            end else if (key_ff >= end_ff) begin
               rsp_status_in = ivt_pkg::STATUS_EMPTY;
            end else if ((count_ff == '0) && (value_ff == default_ff)) begin
               rsp_status_in = ivt_pkg::STATUS_DONE;
            end else if (need_c > ivt_pkg::need_type'(ivt_pkg::TABLE_DEPTH)) begin
               rsp_status_in = ivt_pkg::STATUS_FULL;
            end else begin
               rsp_valid_in = 1'b0;
               lo_in        = lo_c;
               tgt_in       = tgt_c[ivt_pkg::CNT_BITS-1:0];
               cur_in       = hi_c;
               need_in      = need_c[ivt_pkg::CNT_BITS-1:0];
               ins2_in      = !ep_c;
               end_val_in   = q_val_c;
               state_in     = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (cur_ff == tgt_ff) begin
               ctrl.wr_b         = 1'b1;
               ctrl.wr_e         = ins2_ff;
               count_in          = need_ff;
               rsp_valid_in      = 1'b1;
               rsp_read_value_in = '0;
               rsp_status_in     = ivt_pkg::STATUS_DONE;
               state_in          = ST_IDLE;
            end else if (cur_ff > tgt_ff) begin
               // close the gap: the tail moves down one cell
               ctrl.shl        = 1'b1;
               ctrl.shift_from = cur_ff - 1'b1;
               cur_in          = cur_ff - 1'b1;
            end else begin
               // open room for the new boundaries
               ctrl.shr        = 1'b1;
               ctrl.shift_from = cur_ff + 1'b1;
               cur_in          = cur_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         default_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            default_ff <= csr_wdata;
         end
      end
      op_ff             <= op_in;
      key_ff            <= key_in;
      end_ff            <= end_in;
      value_ff          <= value_in;
      lo_ff             <= lo_in;
      tgt_ff            <= tgt_in;
      cur_ff            <= cur_in;
      need_ff           <= need_in;
      ins2_ff           <= ins2_in;
      end_val_ff        <= end_val_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;

   `IVT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted item not taken")
   `IVT_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid, "back-to-back results")
   `IVT_ASSERT_IMPL(a_strobe_idle, clock, reset, rsp_valid, !busy, "result while still working")
   `IVT_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= ivt_pkg::cnt_type'(ivt_pkg::TABLE_DEPTH), "entry count overflow")
   `IVT_ASSERT_IMPL(a_shift_target, clock, reset, state_ff == ST_SHIFT, (tgt_ff > lo_ff) && (tgt_ff <= ivt_pkg::cnt_type'(ivt_pkg::TABLE_DEPTH)), "shift target out of range")

endmodule

/* sim/interval_value_table_checker.sv */
// Scoreboard for the interval value table: mirrors the boundary table and checks every reply.
module interval_value_table_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_op,
   input  ivt_pkg::key_type   req_key,
   input  ivt_pkg::key_type   req_key_end,
   input  ivt_pkg::value_type req_value,
   input  logic               rsp_valid,
   input  ivt_pkg::value_type rsp_read_value,
   input  logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  ivt_pkg::value_type csr_wdata,
   output int                 pending,
   output int                 failures
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      ivt_pkg::value_type read_value;
      logic [1:0]         status;
   } reply_type;

   ivt_pkg::key_type   bound_key [ivt_pkg::TABLE_DEPTH];
   ivt_pkg::value_type bound_val [ivt_pkg::TABLE_DEPTH];
   int                 bound_count;
   ivt_pkg::value_type default_val;
   reply_type          owed_replies [$];

   function automatic int first_at_or_above(ivt_pkg::key_type k);
      int i;
      i = 0;
      while (i < bound_count && bound_key[i] < k) i++;
      return i;
   endfunction

   function automatic ivt_pkg::value_type value_at(ivt_pkg::key_type k);
      ivt_pkg::value_type v;
      v = default_val;
      for (int i = 0; i < bound_count; i++) begin
         if (bound_key[i] > k) break;
         v = bound_val[i];
      end
      return v;
   endfunction

   function automatic logic [1:0] table_assign(ivt_pkg::key_type b, ivt_pkg::key_type e,
                                               ivt_pkg::value_type v);
      ivt_pkg::key_type   nk [ivt_pkg::TABLE_DEPTH];
      ivt_pkg::value_type nv [ivt_pkg::TABLE_DEPTH];
      int                 lo, hi, n, need;
      logic               end_present;
      ivt_pkg::value_type end_val;
      if (b >= e) return ivt_pkg::STATUS_EMPTY;
      if (bound_count == 0 && v == default_val) return ivt_pkg::STATUS_DONE;
      lo = first_at_or_above(b);
      hi = first_at_or_above(e);
      end_present = (hi < bound_count) && (bound_key[hi] == e);
      end_val = value_at(e);
      need = bound_count - (hi - lo) + 1 + (end_present ? 0 : 1);
      if (need > ivt_pkg::TABLE_DEPTH) return ivt_pkg::STATUS_FULL;
      n = 0;
      for (int i = 0; i < lo; i++) begin
         nk[n] = bound_key[i];
         nv[n] = bound_val[i];
         n++;
      end
      nk[n] = b;
      nv[n] = v;
      n++;
      // end keeps whatever was in effect there before the assign
      if (!end_present) begin
         nk[n] = e;
         nv[n] = end_val;
         n++;
      end
      for (int i = hi; i < bound_count; i++) begin
         nk[n] = bound_key[i];
         nv[n] = bound_val[i];
         n++;
      end
      for (int i = 0; i < n; i++) begin
         bound_key[i] = nk[i];
         bound_val[i] = nv[i];
      end
      bound_count = n;
      return ivt_pkg::STATUS_DONE;
   endfunction

   always @(posedge clock) begin
      reply_type want, got;
      if (reset) begin
         bound_count = 0;
         default_val = '0;
         owed_replies.delete();
         failures = 0;
      end else begin
         // compare before predicting: a new item may be taken in the reply cycle
         if (rsp_valid) begin
            got.read_value = rsp_read_value;
            got.status     = rsp_status;
            if (owed_replies.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: unexpected reply read_value %0h status %0d",
                           $realtime, got.read_value, got.status);
            end else begin
               want = owed_replies.pop_front();
               if (got.read_value !== want.read_value || got.status !== want.status) begin
                  failures++;
                  if (failures <= 10)
                     $display("%0t: reply mismatch: expected read_value %0h status %0d, %s",
                              $realtime, want.read_value, want.status,
                              $sformatf("got %0h %0d", got.read_value, got.status));
               end
            end
         end
         if (csr_we) default_val = csr_wdata;
         if (start && !busy) begin
            if (req_op == ivt_pkg::OP_LOOKUP) begin
               want.read_value = value_at(req_key);
               want.status     = ivt_pkg::STATUS_DONE;
            end else begin
               want.read_value = '0;
               want.status     = table_assign(req_key, req_key_end, req_value);
            end
            owed_replies.push_back(want);
         end
      end
      pending = owed_replies.size();
   end

endmodule

/* sim/testbench.sv */
// Top of the interval value table testbench: clock, reset, stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_op;
   ivt_pkg::key_type   req_key;
   ivt_pkg::key_type   req_key_end;
   ivt_pkg::value_type req_value;
   logic               rsp_valid;
   ivt_pkg::value_type rsp_read_value;
   logic [1:0]         rsp_status;
   logic               csr_we;
   ivt_pkg::value_type csr_wdata;
   int                 pending;
   int                 failures;

   always #6 clock = ~clock;

   interval_value_table dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_key_end    (req_key_end),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   interval_value_table_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_key_end    (req_key_end),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .pending        (pending),
      .failures       (failures)
   );

   function automatic int pick_gap(bit burst);
      return burst ? 0 : $urandom_range(0, 3);
   endfunction

   // start stays high between back-to-back items
   task automatic send_item(logic op, ivt_pkg::key_type k, ivt_pkg::key_type e,
                            ivt_pkg::value_type v, int gap);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start       <= 1'b1;
      req_op      <= op;
      req_key     <= k;
      req_key_end <= e;
      req_value   <= v;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_default(ivt_pkg::value_type v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_item(int gap);
      logic               op;
      ivt_pkg::key_type   k, e;
      ivt_pkg::value_type v;
      int                 r, ke;
      op = ($urandom_range(0, 99) < 40) ? ivt_pkg::OP_LOOKUP : ivt_pkg::OP_ASSIGN;
      v  = ivt_pkg::value_type'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 85)
         k = ivt_pkg::key_type'(op == ivt_pkg::OP_LOOKUP ? $urandom_range(0, 330)
                                                         : $urandom_range(8, 320));
      else
         k = ivt_pkg::key_type'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (op == ivt_pkg::OP_LOOKUP) ke = $urandom_range(0, 65535);
      else if (r < 70) ke = int'(k) + int'($urandom_range(1, 24));
      else if (r < 85) ke = int'(k) + int'($urandom_range(25, 400));
      else if (r < 95) ke = int'(k) - int'($urandom_range(0, 3));
      else ke = $urandom_range(0, 65535);
      if (ke > 65535) ke = 65535;
      if (ke < 0) ke = 0;
      e = ivt_pkg::key_type'(ke);
      send_item(op, k, e, v, gap);
   endtask

   initial begin
      bit burst;
      reset       = 1'b1;
      start       = 1'b0;
      req_op      = ivt_pkg::OP_ASSIGN;
      req_key     = '0;
      req_key_end = '0;
      req_value   = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty table, empty intervals, default into empty table
      write_default(8'h5A);
      send_item(ivt_pkg::OP_LOOKUP, 16'd0, 16'd0, 8'd0, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'hFFFF, 16'hFFFF, 8'hFF, pick_gap(0));
      send_item(ivt_pkg::OP_ASSIGN, 16'd100, 16'd100, 8'h11, pick_gap(0));
      send_item(ivt_pkg::OP_ASSIGN, 16'hFFFF, 16'd0, 8'h22, pick_gap(0));
      send_item(ivt_pkg::OP_ASSIGN, 16'd10, 16'd20, 8'h5A, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'd15, 16'd0, 8'd0, pick_gap(0));
      send_item(ivt_pkg::OP_ASSIGN, 16'd100, 16'd200, 8'h00, pick_gap(0));
      send_item(ivt_pkg::OP_ASSIGN, 16'd200, 16'd300, 8'hFF, pick_gap(0));
      // end already a boundary
      send_item(ivt_pkg::OP_ASSIGN, 16'd150, 16'd300, 8'h33, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'd99, 16'd0, 8'd0, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'd100, 16'd0, 8'd0, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'd150, 16'd0, 8'd0, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'd299, 16'd0, 8'd0, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'd300, 16'd0, 8'd0, pick_gap(0));
      send_item(ivt_pkg::OP_ASSIGN, 16'hFFFE, 16'hFFFF, 8'hA5, pick_gap(0));
      // fill the table, then overflow it
      for (int i = 0; i < 5; i++)
         send_item(ivt_pkg::OP_ASSIGN, ivt_pkg::key_type'(400 + 20 * i),
                   ivt_pkg::key_type'(405 + 20 * i),
                   ivt_pkg::value_type'(8'h40 + i), pick_gap(0));
      send_item(ivt_pkg::OP_ASSIGN, 16'd390, 16'd400, 8'hC3, pick_gap(0));
      send_item(ivt_pkg::OP_ASSIGN, 16'd600, 16'd610, 8'h3C, pick_gap(0));
      send_item(ivt_pkg::OP_ASSIGN, 16'd90, 16'd60000, 8'h77, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'd59999, 16'd0, 8'd0, pick_gap(0));

      for (int p = 0; p < 5; p++) begin
         write_default((p == 0) ? 8'hFF : (p == 1) ? 8'h00 :
                       ivt_pkg::value_type'($urandom_range(1, 254)));
         for (int i = 0; i < 130; i++) begin
            if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            random_item(pick_gap(burst));
         end
      end

      // boundary at key zero hides the default from here on
      drain();
      send_item(ivt_pkg::OP_ASSIGN, 16'd0, 16'hFFFF, 8'hFF, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'd0, 16'd0, 8'd0, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'hFFFE, 16'd0, 8'd0, pick_gap(0));
      send_item(ivt_pkg::OP_LOOKUP, 16'hFFFF, 16'd0, 8'd0, pick_gap(0));
      drain();

      if (failures == 0)
         $display("interval_value_table verification clean");
      else
         $display("interval_value_table verification failed");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("interval_value_table verification failed");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/ivt_pkg.sv
rtl/ivt_cell.sv
rtl/interval_value_table.sv
sim/interval_value_table_checker.sv
sim/testbench.sv
